/* rtl/utf8uc_pkg.sv */
// ============================================================================
// utf8uc_pkg
// Shared types and constants of the UTF-8 unique code point collector.
// ============================================================================
`default_nettype none

package utf8uc_pkg;

    localparam int CP_W    = 21;
    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 9;
    localparam int COUNT_W = 10;

    localparam logic [BYTE_W-1:0] C_ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] C_LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] C_LEAD2_CODE  = 8'hC0;
    localparam logic [BYTE_W-1:0] C_LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] C_LEAD3_CODE  = 8'hE0;
    localparam logic [BYTE_W-1:0] C_LOW5        = 8'h1F;
    localparam logic [BYTE_W-1:0] C_LOW4        = 8'h0F;
    localparam logic [BYTE_W-1:0] C_LOW3        = 8'h07;
    localparam logic [BYTE_W-1:0] C_LOW6        = 8'h3F;

    localparam logic [CP_W-1:0] C_CP_ASCII_LIMIT = 21'h00080;

    typedef enum logic [1:0] {
        OUT_ASCII = 2'd0,
        OUT_NEW   = 2'd1,
        OUT_FOUND = 2'd2,
        OUT_FULL  = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT
    } t_state;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] cp;
    } t_job;

endpackage

`default_nettype wire

/* rtl/utf8uc_decoder.sv */
// ============================================================================
// utf8uc_decoder
// Assembles code points from UTF-8 bytes without validation and issues a
// lookup job for every completed sequence.
// ============================================================================
`default_nettype none

module utf8uc_decoder
    import utf8uc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [BYTE_W-1:0] i_text_byte,
    output t_job                   o_job
);

    logic [CP_W-1:0] r_partial;
    logic [CP_W-1:0] n_partial;
    logic [1:0]      r_pending;
    logic [1:0]      n_pending;
    logic            done;
    logic [CP_W-1:0] done_cp;
    logic [CP_W-1:0] shifted;

    always_comb begin
        shifted   = {r_partial[CP_W-7:0], i_text_byte[5:0] & C_LOW6[5:0]};
        n_partial = r_partial;
        n_pending = r_pending;
        done      = 1'b0;
        done_cp   = '0;
        if (r_pending == 2'd0) begin
            if (i_text_byte < C_ASCII_LIMIT) begin
                done    = 1'b1;
                done_cp = {{(CP_W-BYTE_W){1'b0}}, i_text_byte};
            end else if ((i_text_byte & C_LEAD2_MASK) == C_LEAD2_CODE) begin
                n_partial = {{(CP_W-BYTE_W){1'b0}}, i_text_byte & C_LOW5};
                n_pending = 2'd1;
            end else if ((i_text_byte & C_LEAD3_MASK) == C_LEAD3_CODE) begin
                n_partial = {{(CP_W-BYTE_W){1'b0}}, i_text_byte & C_LOW4};
                n_pending = 2'd2;
            end else begin
                n_partial = {{(CP_W-BYTE_W){1'b0}}, i_text_byte & C_LOW3};
                n_pending = 2'd3;
            end
        end else begin
            n_pending = r_pending - 2'd1;
            if (r_pending == 2'd1) begin
                done      = 1'b1;
                done_cp   = shifted;
                n_partial = '0;
            end else begin
                n_partial = shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= 2'd0;
        end else if (i_accept) begin
            r_partial <= n_partial;
            r_pending <= n_pending;
        end
    end

    assign o_job.valid = i_accept & done;
    assign o_job.cp    = done_cp;

endmodule

`default_nettype wire

/* rtl/utf8uc_set_search.sv */
// ============================================================================
// utf8uc_set_search
// Holds the set of stored code points and searches it one entry per cycle
// with a single comparator, appending new points while there is room.
// ============================================================================
`default_nettype none

module utf8uc_set_search
    import utf8uc_pkg::*;
#(
    parameter int SET_DEPTH = 512
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_job               i_job,
    output logic                    o_busy,
    output logic                    o_valid,
    output logic [CP_W-1:0]         o_code_point,
    output logic [1:0]              o_outcome,
    output logic [SLOT_W-1:0]       o_slot,
    output logic [COUNT_W-1:0]      o_stored_count
);

    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

    logic [CP_W-1:0] mem [SET_DEPTH];

    t_state          r_state;
    t_state          n_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   n_addr;
    logic            r_rd_vld;
    logic            n_rd_vld;
    logic [AW-1:0]   r_cmp_idx;
    logic [CP_W-1:0] r_rd_data;
    logic [CP_W-1:0] r_cp;
    logic [CP_W-1:0] n_cp;
    logic            r_out_valid;
    logic            n_out_valid;
    logic [CP_W-1:0] r_out_cp;
    logic [CP_W-1:0] n_out_cp;
    t_outcome        r_out_outcome;
    t_outcome        n_out_outcome;
    logic [AW-1:0]   r_out_slot;
    logic [AW-1:0]   n_out_slot;
    logic            mem_we;
    logic [CW-1:0]   count_m1;
    logic [AW-1:0]   last_idx;
    logic [AW+SLOT_W-1:0]  slot_ext;
    logic [CW+COUNT_W-1:0] count_ext;

    assign count_m1 = r_count - 1'b1;
    assign last_idx = count_m1[AW-1:0];

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_addr        = r_addr;
        n_rd_vld      = 1'b0;
        n_cp          = r_cp;
        n_out_valid   = 1'b0;
        n_out_cp      = r_out_cp;
        n_out_outcome = r_out_outcome;
        n_out_slot    = r_out_slot;
        mem_we        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job.valid) begin
                    if (i_job.cp < C_CP_ASCII_LIMIT) begin
                        n_out_valid   = 1'b1;
                        n_out_cp      = i_job.cp;
                        n_out_outcome = OUT_ASCII;
                        n_out_slot    = '0;
                    end else begin
                        n_cp   = i_job.cp;
                        n_addr = '0;
                        if (r_count == '0) begin
                            n_state = ST_INSERT;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                n_rd_vld = 1'b1;
                if (r_addr != last_idx) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_rd_vld) begin
                    if (r_rd_data == r_cp) begin
                        n_rd_vld      = 1'b0;
                        n_state       = ST_IDLE;
                        n_out_valid   = 1'b1;
                        n_out_cp      = r_cp;
                        n_out_outcome = OUT_FOUND;
                        n_out_slot    = r_cmp_idx;
                    end else if (r_cmp_idx == last_idx) begin
                        n_rd_vld = 1'b0;
                        n_state  = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_out_cp    = r_cp;
                if (r_count < DEPTH_C) begin
                    mem_we        = 1'b1;
                    n_out_outcome = OUT_NEW;
                    n_out_slot    = r_count[AW-1:0];
                    n_count       = r_count + 1'b1;
                end else begin
                    n_out_outcome = OUT_FULL;
                    n_out_slot    = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr        <= n_addr;
        r_cp          <= n_cp;
        r_cmp_idx     <= r_addr;
        r_out_cp      <= n_out_cp;
        r_out_outcome <= n_out_outcome;
        r_out_slot    <= n_out_slot;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[AW-1:0]] <= r_cp;
        end
        r_rd_data <= mem[r_addr];
    end

    assign slot_ext  = {{SLOT_W{1'b0}}, r_out_slot};
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    assign o_busy         = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_code_point   = r_out_cp;
    assign o_outcome      = r_out_outcome;
    assign o_slot         = slot_ext[SLOT_W-1:0];
    assign o_stored_count = count_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

/* rtl/utf8_unique_codepoint_collector_unit.sv */
// ============================================================================
// utf8_unique_codepoint_collector_unit
// Decodes a UTF-8 byte stream and collects the distinct code points at or
// above 0x80 in a set of SET_DEPTH entries.
// ============================================================================
// A byte is taken when i_start is high and o_busy is low. A byte that does
// not complete a sequence, or that completes one below 0x80, leaves o_busy
// low, so the next byte may follow in the next cycle; a result for a
// completed point below 0x80 appears in the cycle after its byte. A completed
// point at or above 0x80 is compared with the stored entries one per cycle
// through the single read port of the set memory: o_busy stays high while
// the entries from slot 0 to the matching slot, or all stored entries for
// a new point, are read and compared; a new point is stored if there is
// room, with no search when the set is empty. The result then shows on
// the o_ ports for one cycle under o_valid and must be taken there, since
// the receiver cannot hold it off. The set needs no clearing after reset.
`default_nettype none

module utf8_unique_codepoint_collector_unit
    import utf8uc_pkg::*;
#(
    parameter int SET_DEPTH = 512
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [BYTE_W-1:0]  i_text_byte,
    output logic                    o_busy,
    output logic                    o_valid,
    output logic [CP_W-1:0]         o_code_point,
    output logic [1:0]              o_outcome,
    output logic [SLOT_W-1:0]       o_slot,
    output logic [COUNT_W-1:0]      o_stored_count
);

    logic accept;
    t_job job;

    assign accept = i_start & ~o_busy;

    utf8uc_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .o_job       (job)
    );

    utf8uc_set_search #(
        .SET_DEPTH (SET_DEPTH)
    ) u_set_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job),
        .o_busy         (o_busy),
        .o_valid        (o_valid),
        .o_code_point   (o_code_point),
        .o_outcome      (o_outcome),
        .o_slot         (o_slot),
        .o_stored_count (o_stored_count)
    );

endmodule

`default_nettype wire

/* rtl/utf8uc_checker.sv */
// ============================================================================
// utf8uc_checker
// Port-level checks of the collector, bound to the top level.
// ============================================================================
`default_nettype none

module utf8uc_checker
    import utf8uc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_start,
    input wire logic               o_busy,
    input wire logic               o_valid,
    input wire logic [CP_W-1:0]    o_code_point,
    input wire logic [1:0]         o_outcome,
    input wire logic [SLOT_W-1:0]  o_slot,
    input wire logic [COUNT_W-1:0] o_stored_count
);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("Busy rose without a transaction on the input.");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("Result strobed while a search is still running.");

    a_ascii_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_outcome == OUT_ASCII) == (o_code_point < C_CP_ASCII_LIMIT)))
        else $error("Outcome does not match the code point range.");

    a_count_on_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stored_count != $past(o_stored_count)) |-> (o_valid && (o_outcome == OUT_NEW)))
        else $error("Stored count changed without a newly stored point.");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_outcome == OUT_ASCII) || (o_outcome == OUT_FULL)))
        |-> (o_slot == '0))
        else $error("Slot is not zero for an ignored or dropped point.");

endmodule

bind utf8_unique_codepoint_collector_unit utf8uc_checker u_utf8uc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_valid        (o_valid),
    .o_code_point   (o_code_point),
    .o_outcome      (o_outcome),
    .o_slot         (o_slot),
    .o_stored_count (o_stored_count)
);

`default_nettype wire
